// ===== design/spg_pkg.sv =====
//------------------------------------------------------------------------------
// spg_pkg
// Shared types, constants and the sample quantizer for the servo pulse generator.
//------------------------------------------------------------------------------
`default_nettype none

package spg_pkg;

	localparam int CHANNELS  = 4;
	localparam int OUT_LEVELS = 4;

	localparam logic [7:0] FRAME_LENGTH_RST = 8'd71;

	// visible level bits that can ever be high
	localparam logic [OUT_LEVELS-1:0] LEVEL_MASK = (CHANNELS >= OUT_LEVELS) ?
		{OUT_LEVELS{1'b1}} : OUT_LEVELS'((1 << CHANNELS) - 1);

	typedef enum logic [1:0] {
		CMD_FRAME  = 2'd0,
		CMD_FINE   = 2'd1,
		CMD_SAMPLE = 2'd2,
		CMD_DIRECT = 2'd3
	} cmd_t;

	// events broadcast from the sequencing logic to every channel
	typedef struct packed {
		logic arm;
		logic raise;
		logic fine;
	} chan_ctl_t;

	localparam int NUM_BOUNDS = 9;
	localparam logic [7:0] QUANT_BOUNDS [NUM_BOUNDS] = '{
		8'd40, 8'd61, 8'd82, 8'd103, 8'd131, 8'd152, 8'd173, 8'd194, 8'd215
	};

	// width = 2 + number of bounds at or below the sample
	function automatic logic [7:0] quantize(input logic [7:0] s);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < NUM_BOUNDS; i++) begin
			if (s >= QUANT_BOUNDS[i])
				n = n + 4'd1;
		end
		return 8'd2 + {4'd0, n};
	endfunction

endpackage

`default_nettype wire

// ===== design/spg_if.sv =====
//------------------------------------------------------------------------------
// spg_if
// Valid/ready channel interfaces: input items, result items, configuration.
//------------------------------------------------------------------------------
`default_nettype none

interface spg_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [1:0] channel;
	logic [7:0] value;

	modport source (output valid, cmd, channel, value, input ready);
	modport sink   (input valid, cmd, channel, value, output ready);
endinterface

interface spg_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] servo_levels;

	modport source (output valid, servo_levels, input ready);
	modport sink   (input valid, servo_levels, output ready);
endinterface

interface spg_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== design/spg_frame.sv =====
//------------------------------------------------------------------------------
// spg_frame
// Frame counter: arms the pulse counters and raises all outputs once a frame.
//------------------------------------------------------------------------------
`default_nettype none

module spg_frame (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       tick,
	input  wire logic [7:0] frame_length,
	output logic            arm,
	output logic            raise
);

	logic [7:0] frame_count_q;

	assign arm   = (frame_count_q == 8'd1);
	assign raise = (frame_count_q == frame_length);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= 8'd0;
		end else if (tick) begin
			frame_count_q <= (raise ? 8'd0 : frame_count_q) + 8'd1;
		end
	end

endmodule

`default_nettype wire

// ===== design/spg_channel.sv =====
//------------------------------------------------------------------------------
// spg_channel
// One servo channel: stored width, pulse counter, arm flag and output level.
//------------------------------------------------------------------------------
`default_nettype none

module spg_channel (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spg_pkg::chan_ctl_t ctl,
	input  wire logic              wr_en,
	input  wire logic [7:0]        wr_width,
	output logic                   level_next
);

	logic [7:0] pulse_count_q;
	logic [7:0] pulse_width_q;
	logic       armed_q;
	logic       level_q;
	logic       hit;

	assign hit = (pulse_count_q == pulse_width_q);

	always_comb begin
		level_next = level_q;
		if (ctl.raise)
			level_next = 1'b1;
		else if (ctl.fine && hit)
			level_next = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_count_q <= 8'd0;
			pulse_width_q <= 8'd0;
			armed_q       <= 1'b0;
			level_q       <= 1'b0;
		end else begin
			level_q <= level_next;
			if (ctl.arm)
				armed_q <= 1'b1;
			if (ctl.fine) begin
				if (hit) begin
					pulse_count_q <= 8'd0;
					armed_q       <= 1'b0;
				end else if (armed_q) begin
					pulse_count_q <= pulse_count_q + 8'd1;
				end
			end
			if (wr_en)
				pulse_width_q <= wr_width;
		end
	end

endmodule

`default_nettype wire

// ===== design/four_channel_servo_pulse_generator_core.sv =====
//------------------------------------------------------------------------------
// four_channel_servo_pulse_generator_core
// Servo pulse generator with frame and fine timing ticks and per-channel widths.
//------------------------------------------------------------------------------
// Usage:
//   item_in  : one command per item (frame tick, fine tick, quantized sample,
//              direct width) with a channel select and an 8-bit value.
//   item_out : one item per command, the four output levels after it.
//   cfg      : write of frame_length, always ready; write only while idle.
// Path: an accepted item lands in the input register, is processed from it
//   once the result register can take it, and its result is then shown from
//   the result register until the receiver takes it.
// Throughput: one item per cycle while the receiver takes every result; the
//   channel cells and the frame counter are updated from the input register.
// Reset: all counters, widths and levels clear, item_out.valid low, frame_length
//   returns to 71, both registers empty.
// Stall: while a result waits, the input register still fills once; further
//   items are held off until the receiver takes the result.
//------------------------------------------------------------------------------
`default_nettype none

module four_channel_servo_pulse_generator_core (
	input  wire logic clk,
	input  wire logic arst_n,
	spg_in_if.sink    item_in,
	spg_out_if.source item_out,
	spg_cfg_if.sink   cfg
);

	logic                    valid_s1;
	spg_pkg::cmd_t           cmd_s1;
	logic [1:0]              channel_s1;
	logic [7:0]              value_s1;

	logic                    out_valid_q;
	logic [3:0]              levels_q;
	logic [7:0]              frame_length_q;

	logic                    advance;
	logic                    accept;
	logic                    frame_arm;
	logic                    frame_raise;
	logic                    wr_any;
	logic [7:0]              wr_width;
	spg_pkg::chan_ctl_t      ctl;
	logic [spg_pkg::CHANNELS-1:0] level_next;
	logic [3:0]              levels_d;

	assign advance       = valid_s1 && (!out_valid_q || item_out.ready);
	assign item_in.ready = !valid_s1 || advance;
	assign accept        = item_in.valid && item_in.ready;
	assign cfg.ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q <= spg_pkg::FRAME_LENGTH_RST;
		end else if (cfg.valid) begin
			frame_length_q <= cfg.data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= spg_pkg::cmd_t'(item_in.cmd);
			channel_s1 <= item_in.channel;
			value_s1   <= item_in.value;
		end
	end

	spg_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (advance && (cmd_s1 == spg_pkg::CMD_FRAME)),
		.frame_length (frame_length_q),
		.arm          (frame_arm),
		.raise        (frame_raise)
	);

	always_comb begin
		ctl.arm   = advance && (cmd_s1 == spg_pkg::CMD_FRAME) && frame_arm;
		ctl.raise = advance && (cmd_s1 == spg_pkg::CMD_FRAME) && frame_raise;
		ctl.fine  = advance && (cmd_s1 == spg_pkg::CMD_FINE);
	end

	assign wr_any   = advance && ((cmd_s1 == spg_pkg::CMD_SAMPLE) ||
	                              (cmd_s1 == spg_pkg::CMD_DIRECT));
	assign wr_width = (cmd_s1 == spg_pkg::CMD_SAMPLE) ? spg_pkg::quantize(value_s1)
	                                                  : value_s1;

	for (genvar i = 0; i < spg_pkg::CHANNELS; i++) begin : g_chan
		spg_channel u_channel (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.wr_en      (wr_any && (int'(channel_s1) == i)),
			.wr_width   (wr_width),
			.level_next (level_next[i])
		);
	end

	for (genvar i = 0; i < 4; i++) begin : g_levels
		if (i < spg_pkg::CHANNELS) begin : g_on
			assign levels_d[i] = level_next[i];
		end else begin : g_off
			assign levels_d[i] = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || item_out.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			levels_q <= levels_d;
	end

	assign item_out.valid        = out_valid_q;
	assign item_out.servo_levels = levels_q;

	a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item did not reach the input register");

	a_advance_fills_out : assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed item produced no result");

	a_raise_all_high : assert property (@(posedge clk) disable iff (!arst_n)
		ctl.raise |=> (levels_q == spg_pkg::LEVEL_MASK))
		else $error("frame start did not raise all outputs");

endmodule

`default_nettype wire

// ===== test/four_channel_servo_pulse_generator_core_tb.sv =====
//------------------------------------------------------------------------------
// four_channel_servo_pulse_generator_core_tb
// Drives frame ticks, fine ticks, quantized samples and direct widths into the
// servo pulse generator. An in-bench model of the frame and channel counters
// predicts the four output levels for every item. Both handshakes idle and
// stall at random, and frame_length is swept over several values between
// phases, including the extremes.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_channel_servo_pulse_generator_core_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;
	localparam int HOLD_AFTER  = 500;

	class servo_scoreboard;
		logic [7:0] frame_len;
		logic [7:0] frame_cnt;
		logic [7:0] pulse_cnt [spg_pkg::CHANNELS];
		logic [7:0] pulse_wid [spg_pkg::CHANNELS];
		bit         armed     [spg_pkg::CHANNELS];
		bit         lvl       [spg_pkg::CHANNELS];
		logic [3:0] levels_q  [$];
		int         mismatches;
		int         accepted;

		function new();
			frame_len = spg_pkg::FRAME_LENGTH_RST;
			frame_cnt = '0;
			for (int c = 0; c < spg_pkg::CHANNELS; c++) begin
				pulse_cnt[c] = '0;
				pulse_wid[c] = '0;
				armed[c]     = 1'b0;
				lvl[c]       = 1'b0;
			end
			mismatches = 0;
			accepted   = 0;
		endfunction

		function void set_frame_length(logic [7:0] v);
			frame_len = v;
		endfunction

		function int pending();
			return levels_q.size();
		endfunction

		function logic [7:0] quantize_sample(logic [7:0] s);
			if (s < 8'd40)  return 8'd2;
			if (s < 8'd61)  return 8'd3;
			if (s < 8'd82)  return 8'd4;
			if (s < 8'd103) return 8'd5;
			if (s < 8'd131) return 8'd6;
			if (s < 8'd152) return 8'd7;
			if (s < 8'd173) return 8'd8;
			if (s < 8'd194) return 8'd9;
			if (s < 8'd215) return 8'd10;
			return 8'd11;
		endfunction

		// advance the model by one accepted item and queue the expected levels
		function void note_item(spg_pkg::cmd_t cmd, logic [1:0] ch, logic [7:0] v);
			logic [3:0] levels;
			accepted++;
			case (cmd)
				spg_pkg::CMD_FRAME: begin
					if (frame_cnt == 8'd1)
						for (int c = 0; c < spg_pkg::CHANNELS; c++) armed[c] = 1'b1;
					if (frame_cnt == frame_len) begin
						frame_cnt = '0;
						for (int c = 0; c < spg_pkg::CHANNELS; c++) lvl[c] = 1'b1;
					end
					frame_cnt = frame_cnt + 8'd1;
				end
				spg_pkg::CMD_FINE: begin
					for (int c = 0; c < spg_pkg::CHANNELS; c++) begin
						if (pulse_cnt[c] == pulse_wid[c]) begin
							lvl[c]       = 1'b0;
							pulse_cnt[c] = '0;
							armed[c]     = 1'b0;
						end else if (armed[c]) begin
							pulse_cnt[c] = pulse_cnt[c] + 8'd1;
						end
					end
				end
				default: begin
					if (int'(ch) < spg_pkg::CHANNELS)
						pulse_wid[ch] = (cmd == spg_pkg::CMD_SAMPLE) ?
							quantize_sample(v) : v;
				end
			endcase
			levels = '0;
			for (int c = 0; c < spg_pkg::CHANNELS && c < 4; c++)
				levels[c] = lvl[c];
			levels_q.push_back(levels);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_levels(logic [3:0] got);
			logic [3:0] want;
			if (levels_q.size() == 0) begin
				report($sformatf("levels %b with no item outstanding", got));
			end else begin
				want = levels_q.pop_front();
				if (got !== want)
					report($sformatf("servo_levels got %b want %b", got, want));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   no_idle;
	bit   hold_off;
	int   cycles;

	spg_in_if  in_ch ();
	spg_out_if out_ch ();
	spg_cfg_if cfg_ch ();

	servo_scoreboard sb;

	four_channel_servo_pulse_generator_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (in_ch),
		.item_out (out_ch),
		.cfg      (cfg_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.cmd     = spg_pkg::CMD_FRAME;
		in_ch.channel = '0;
		in_ch.value   = '0;
		out_ch.ready  = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.data   = '0;
		no_idle       = 1'b0;
		hold_off      = 1'b0;
		sb            = new();
	end

	task send_item(spg_pkg::cmd_t cmd, logic [1:0] ch, logic [7:0] v);
		while (!no_idle && $urandom_range(99) < 22) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid   = 1'b1;
		in_ch.cmd     = cmd;
		in_ch.channel = ch;
		in_ch.value   = v;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_item(cmd, ch, v);
		@(negedge clk);
	endtask

	// wait until all results are back and the pipeline has drained
	task wait_idle();
		in_ch.valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_frame_length(logic [7:0] v);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data  = v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		sb.set_frame_length(v);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task run_phase(logic [7:0] flen, int n_items);
		int frame_pct;
		int rest;
		int r;
		spg_pkg::cmd_t cmd;
		logic [7:0] v;
		wait_idle();
		write_frame_length(flen);
		// long frames need mostly frame ticks to ever reach the rising edge
		frame_pct = (flen > 8'd40 || flen == 8'd0) ? 85 : 35;
		rest = 100 - frame_pct;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			if (r < frame_pct)
				cmd = spg_pkg::CMD_FRAME;
			else if (r < frame_pct + rest * 6 / 10)
				cmd = spg_pkg::CMD_FINE;
			else if (r < frame_pct + rest * 8 / 10)
				cmd = spg_pkg::CMD_SAMPLE;
			else
				cmd = spg_pkg::CMD_DIRECT;
			if (cmd == spg_pkg::CMD_DIRECT && $urandom_range(3) != 0)
				v = 8'($urandom_range(12));
			else
				v = 8'($urandom_range(255));
			send_item(cmd, 2'($urandom_range(3)), v);
		end
	endtask

	// input driver and phase sequence
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait_idle();
		write_frame_length(8'd3);
		@(negedge clk);
		send_item(spg_pkg::CMD_DIRECT, 2'd0, 8'd0);
		send_item(spg_pkg::CMD_FINE,   2'd3, 8'hFF);
		send_item(spg_pkg::CMD_DIRECT, 2'd1, 8'd255);
		send_item(spg_pkg::CMD_SAMPLE, 2'd2, 8'd0);
		send_item(spg_pkg::CMD_SAMPLE, 2'd3, 8'd255);
		send_item(spg_pkg::CMD_SAMPLE, 2'd2, 8'd39);
		send_item(spg_pkg::CMD_SAMPLE, 2'd2, 8'd40);
		send_item(spg_pkg::CMD_SAMPLE, 2'd3, 8'd214);
		send_item(spg_pkg::CMD_SAMPLE, 2'd3, 8'd215);
		repeat (4) send_item(spg_pkg::CMD_FRAME, 2'd1, 8'hFF);
		// width 0 lowers ch0 on the first fine tick after the frame start
		send_item(spg_pkg::CMD_FINE,   2'd0, 8'h55);
		send_item(spg_pkg::CMD_FRAME,  2'd2, 8'hAA);
		send_item(spg_pkg::CMD_DIRECT, 2'd2, 8'd3);
		repeat (5) send_item(spg_pkg::CMD_FINE, 2'd0, 8'h00);

		run_phase(8'd2, 150);
		no_idle = 1'b1;
		run_phase(8'd4, 150);
		no_idle = 1'b0;
		run_phase(8'd255, 380);
		run_phase(8'd0, 320);
		run_phase(8'd1, 80);
		run_phase(8'($urandom_range(20, 5)), 100);

		in_ch.valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// result receiver
	initial begin
		forever begin
			@(negedge clk);
			out_ch.ready = hold_off ? 1'b0 :
				(no_idle ? 1'b1 : ($urandom_range(99) >= 22));
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				sb.check_levels(out_ch.servo_levels);
		end
	end

	// one long receiver stall while the sender keeps offering items
	initial begin
		@(posedge clk);
		while (sb.accepted < HOLD_AFTER) @(posedge clk);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== four_channel_servo_pulse_generator_core.f =====
design/spg_pkg.sv
design/spg_if.sv
design/spg_frame.sv
design/spg_channel.sv
design/four_channel_servo_pulse_generator_core.sv
test/four_channel_servo_pulse_generator_core_tb.sv
